### hw/rtl/tpm_pkg.sv
// Shared constants, types and helpers for the tree parity machine.
`default_nettype none

package tpm_pkg;

  // Field widths fixed by the interface
  localparam int OP_W    = 2;
  localparam int UNIT_W  = 5;
  localparam int BITS_W  = 30;
  localparam int WIDX_W  = 10;
  localparam int W_W     = 4;
  localparam int HID_W   = 30;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 5;
  localparam int TERM_W  = 5;

  // Limits of the configuration registers
  localparam int UNITS_CAP  = 30;
  localparam int INPUTS_CAP = 30;
  localparam logic [4:0] CNT_MIN = 5'd4;
  localparam logic [4:0] CNT_MAX = 5'd30;
  localparam logic [2:0] MW_MIN  = 3'd3;
  localparam logic [2:0] MW_MAX  = 3'd6;

  localparam logic [4:0] HC_RST = 5'd4;
  localparam logic [4:0] IPU_RST = 5'd4;
  localparam logic [2:0] MW_RST = 3'd3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PARITY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RW     = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_HIDDEN_COUNT    = 2'd0;
  localparam logic [CIDX_W-1:0] REG_INPUTS_PER_UNIT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_WEIGHT      = 2'd2;

  typedef struct packed {
    logic       tau;
    logic [2:0] lim;
  } lane_ctl_t;

  // Saturate to -lim..lim
  function automatic logic signed [W_W-1:0] clip_w(input logic signed [W_W:0] v,
                                                  input logic [2:0] lim);
    logic signed [W_W:0] hi;
    logic signed [W_W:0] lo;
    logic signed [W_W:0] r;
    hi = $signed({2'b00, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[W_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tree_parity_machine_core.sv
// Tree parity machine core: compute, Hebbian update and weight access.
//
//   channel   ports                               handshake
//   request   in_*                                start & !busy
//   result    out_*                               out_valid, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_wdata        cfg_we, immediate
//
// Steps: compute runs read, lanes, adder tree, sign; read/write end after the weight access.
// Update walks the units in use: a unit whose sign differs from tau is skipped, else the
// two weight rows that hold the unit get a read-modify-write.
// The weight store is two banks of rows; each access reads one row pair.
// Reset is synchronous; row valid bits make the weights read as zero at once.
// Results are never held off; one request is in flight at a time.
`default_nettype none

module tree_parity_machine_core #(
  parameter int MAX_UNITS  = 30,
  parameter int MAX_INPUTS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tpm_pkg::OP_W-1:0]             in_opcode,
  input  logic [tpm_pkg::UNIT_W-1:0]           in_unit_index,
  input  logic [tpm_pkg::BITS_W-1:0]           in_input_bits,
  input  logic                                 in_last_unit,
  input  logic                                 in_tau_in,
  input  logic [tpm_pkg::WIDX_W-1:0]           in_weight_index,
  input  logic signed [tpm_pkg::W_W-1:0]       in_weight_value,
  output logic                                 out_valid,
  output logic                                 out_tau_out,
  output logic [tpm_pkg::HID_W-1:0]            out_hidden_outputs,
  output logic signed [tpm_pkg::W_W-1:0]       out_weight_out,
  output logic [tpm_pkg::KIND_W-1:0]           out_result_kind,
  input  logic                                 cfg_we,
  input  logic [tpm_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [tpm_pkg::CDAT_W-1:0]           cfg_wdata
);

  import tpm_pkg::*;

  localparam int NU      = (MAX_UNITS < UNITS_CAP) ? MAX_UNITS : UNITS_CAP;
  localparam int NL      = (MAX_INPUTS < INPUTS_CAP) ? MAX_INPUTS : INPUTS_CAP;
  localparam int FLAT    = NU * NL;
  localparam int FW      = $clog2(FLAT);
  localparam int ROW     = 2 ** $clog2(NL);
  localparam int RB      = $clog2(ROW);
  localparam int RW      = ROW * W_W;
  localparam int PW      = 2 * RW;
  localparam int PE      = 2 * ROW;
  localparam int NROWS   = (FLAT + ROW - 1) / ROW;
  localparam int NRA     = NROWS + 1;
  localparam int ROWI_W  = $clog2(NRA);
  localparam int BANK_D  = (NRA + 1) / 2;
  localparam int BA_W    = $clog2(BANK_D);
  localparam int UI_W    = $clog2(NU);
  localparam int K_W     = $clog2(NU + 1);
  localparam int SUM_W   = $clog2(NL * 8) + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADDR = 6'b000010,
    S_RD   = 6'b000100,
    S_LOAD = 6'b001000,
    S_EXEC = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  state_t state_r;

  // configuration
  logic [4:0] hc_r;
  logic [4:0] ipu_r;
  logic [2:0] mw_r;
  logic [4:0] units;
  logic [4:0] n_in;

  // latched request
  logic [OP_W-1:0]       op_r;
  logic [UNIT_W-1:0]     unit_r;
  logic [NL-1:0]         bits_r;
  logic                  last_r;
  logic                  tau_r;
  logic [WIDX_W-1:0]     idx_r;
  logic signed [W_W-1:0] wval_r;

  // control state
  logic [K_W-1:0]  k_r;
  logic [NU-1:0]   signs_r;
  logic [NU-1:0]   signs_nxt;
  logic            parity_r;
  logic            parity_nxt;
  logic [NRA-1:0]  valid_r;

  // datapath
  logic [9:0]           mul_a;
  logic [9:0]           prod;
  logic [FW-1:0]        base_r;
  logic                 rng_r;
  logic [FW-RB-1:0]     r0;
  logic [ROWI_W-1:0]    r1;
  logic [BA_W-1:0]      ea;
  logic [BA_W-1:0]      oa;
  logic [BA_W-1:0]      ea_r;
  logic [BA_W-1:0]      oa_r;
  logic [ROWI_W-1:0]    lo_row_r;
  logic [ROWI_W-1:0]    hi_row;
  logic                 odd_r;
  logic [RB-1:0]        col0_r;
  logic [RB+1:0]        shamt;
  logic [RW-1:0]        ev_rdata;
  logic [RW-1:0]        od_rdata;
  logic [RW-1:0]        lo_d;
  logic [RW-1:0]        hi_d;
  logic [PW-1:0]        pair;
  logic [PW-1:0]        pair_sh;
  logic [PW-1:0]        pair_r;
  logic [NL-1:0][W_W-1:0] win_r;
  logic [NL-1:0][W_W-1:0] win_nxt;
  logic [NL-1:0]        x_r;
  logic [NL-1:0]        ist_rdata;

  logic [NL-1:0][TERM_W-1:0] terms;
  logic [NL-1:0][W_W-1:0]    upd_w;
  logic [NL-1:0][W_W-1:0]    new_win;
  logic [NL-1:0]             lm;
  logic [4:0]                cnt;
  logic [PW-1:0]             nw_sh;
  logic [PE-1:0]             em;
  logic [PW-1:0]             npair;
  logic signed [W_W-1:0]     wclip;
  logic signed [SUM_W-1:0]   dot;
  logic                      pos;
  lane_ctl_t                 lctl;

  logic                 bank_we;
  logic                 ist_we;
  logic                 accept;
  logic [HID_W-1:0]     signs_pad;
  logic [HID_W-1:0]     hid_mask;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_tau_r;
  logic [HID_W-1:0]          out_hid_r;
  logic signed [W_W-1:0]     out_w_r;
  logic [KIND_W-1:0]         out_kind_r;

  assign units  = (hc_r > 5'(NU)) ? 5'(NU) : hc_r;
  assign n_in   = (ipu_r > 5'(NL)) ? 5'(NL) : ipu_r;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // one shared small multiplier: unit base or index bound
  always_comb begin
    if (op_r == OP_READ || op_r == OP_WRITE) begin
      mul_a = 10'(units);
    end else if (op_r == OP_UPDATE) begin
      mul_a = 10'(k_r);
    end else begin
      mul_a = 10'(unit_r);
    end
    prod = mul_a * 10'(n_in);
  end

  // row pair addressing from the flat base
  assign r0     = base_r[FW-1:RB];
  assign r1     = ROWI_W'(r0) + ROWI_W'(1);
  assign ea     = BA_W'(r1 >> 1);
  assign oa     = BA_W'(r0 >> 1);
  assign hi_row = lo_row_r + ROWI_W'(1);
  assign shamt  = {col0_r, 2'b00};

  assign lo_d    = odd_r ? od_rdata : ev_rdata;
  assign hi_d    = odd_r ? ev_rdata : od_rdata;
  assign pair    = {(valid_r[hi_row] ? hi_d : RW'(0)), (valid_r[lo_row_r] ? lo_d : RW'(0))};
  assign pair_sh = pair >> shamt;

  // lanes
  assign lctl.tau = tau_r;
  assign lctl.lim = mw_r;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    tpm_lane u_lane (
      .w     (win_r[i]),
      .x     (x_r[i]),
      .ctl   (lctl),
      .term  (terms[i]),
      .w_upd (upd_w[i])
    );
  end

  tpm_merge #(
    .NL    (NL),
    .SUM_W (SUM_W)
  ) u_merge (
    .clk   (clk),
    .terms (terms),
    .sum   (dot)
  );

  assign pos   = !dot[SUM_W-1] && (dot != '0);
  assign wclip = clip_w({wval_r[W_W-1], wval_r}, mw_r);
  assign cnt   = (op_r == OP_WRITE) ? 5'd1 : n_in;

  // lanes past the unit's inputs see zero weights
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lm[i] = (5'(i) < cnt);
      win_nxt[i] = lm[i] ? pair_sh[i*W_W +: W_W] : '0;
      if (op_r == OP_WRITE) begin
        new_win[i] = (i == 0) ? wclip : '0;
      end else begin
        new_win[i] = upd_w[i];
      end
    end
  end

  // splice the changed window back into the row pair
  assign nw_sh = PW'(new_win) << shamt;
  assign em    = PE'(lm) << col0_r;

  always_comb begin
    for (int p = 0; p < PE; p++) begin
      npair[p*W_W +: W_W] = em[p] ? nw_sh[p*W_W +: W_W] : pair_r[p*W_W +: W_W];
    end
  end

  assign bank_we = (state_r == S_EXEC) &&
                   ((op_r == OP_UPDATE) || (op_r == OP_WRITE && rng_r));

  tpm_ram #(.WIDTH(RW), .DEPTH(BANK_D)) u_bank_even (
    .clk   (clk),
    .we    (bank_we),
    .waddr (ea_r),
    .wdata (odd_r ? npair[PW-1:RW] : npair[RW-1:0]),
    .re    (state_r == S_RD),
    .raddr (ea),
    .rdata (ev_rdata)
  );

  tpm_ram #(.WIDTH(RW), .DEPTH(BANK_D)) u_bank_odd (
    .clk   (clk),
    .we    (bank_we),
    .waddr (oa_r),
    .wdata (odd_r ? npair[RW-1:0] : npair[PW-1:RW]),
    .re    (state_r == S_RD),
    .raddr (oa),
    .rdata (od_rdata)
  );

  // input words per unit, used by the update walk
  assign ist_we = accept && (in_opcode == OP_COMPUTE) && (in_unit_index < units);

  tpm_ram #(.WIDTH(NL), .DEPTH(NU)) u_input_store (
    .clk   (clk),
    .we    (ist_we),
    .waddr (in_unit_index[UI_W-1:0]),
    .wdata (in_input_bits[NL-1:0]),
    .re    (state_r == S_RD),
    .raddr (k_r[UI_W-1:0]),
    .rdata (ist_rdata)
  );

  // sign and parity of the finished dot product
  always_comb begin
    signs_nxt  = signs_r;
    parity_nxt = parity_r;
    if (state_r == S_SUM) begin
      if (rng_r) begin
        signs_nxt[unit_r[UI_W-1:0]] = pos;
        parity_nxt = parity_r ^ !pos;
      end
      // parity restarts at +1 once tau has gone out
      if (last_r) begin
        parity_nxt = 1'b1;
      end
    end
  end

  assign signs_pad = HID_W'(signs_nxt);

  always_comb begin
    for (int k = 0; k < HID_W; k++) begin
      hid_mask[k] = signs_pad[k] && (5'(k) < units);
    end
  end

  always_comb begin
    case (state_r)
      S_ADDR:  out_valid_nxt = (op_r == OP_UPDATE) && (5'(k_r) == units);
      S_EXEC:  out_valid_nxt = (op_r == OP_READ) || (op_r == OP_WRITE);
      S_SUM:   out_valid_nxt = last_r;
      default: out_valid_nxt = 1'b0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      signs_r     <= '0;
      parity_r    <= 1'b1;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      hc_r        <= HC_RST;
      ipu_r       <= IPU_RST;
      mw_r        <= MW_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      signs_r     <= signs_nxt;
      parity_r    <= parity_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_HIDDEN_COUNT: begin
            hc_r <= (cfg_wdata < CNT_MIN) ? CNT_MIN :
                    (cfg_wdata > CNT_MAX) ? CNT_MAX : cfg_wdata;
          end
          REG_INPUTS_PER_UNIT: begin
            ipu_r <= (cfg_wdata < CNT_MIN) ? CNT_MIN :
                     (cfg_wdata > CNT_MAX) ? CNT_MAX : cfg_wdata;
          end
          REG_MAX_WEIGHT: begin
            mw_r <= (cfg_wdata[2:0] < MW_MIN) ? MW_MIN :
                    (cfg_wdata[2:0] > MW_MAX) ? MW_MAX : cfg_wdata[2:0];
          end
          default: begin
          end
        endcase
      end

      if (bank_we) begin
        valid_r <= valid_r | (NRA'(1) << lo_row_r) | (NRA'(1) << hi_row);
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            k_r     <= '0;
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (op_r == OP_UPDATE) begin
            if (5'(k_r) == units) begin
              state_r <= S_IDLE;
            end else if (signs_r[k_r[UI_W-1:0]] != tau_r) begin
              k_r <= k_r + K_W'(1);
            end else begin
              state_r <= S_RD;
            end
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (op_r == OP_COMPUTE) begin
            state_r <= S_SUM;
          end else if (op_r == OP_UPDATE) begin
            k_r     <= k_r + K_W'(1);
            state_r <= S_ADDR;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SUM: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      unit_r <= in_unit_index;
      bits_r <= in_input_bits[NL-1:0];
      last_r <= in_last_unit;
      tau_r  <= in_tau_in;
      idx_r  <= in_weight_index;
      wval_r <= in_weight_value;
    end

    if (state_r == S_ADDR) begin
      if (op_r == OP_READ || op_r == OP_WRITE) begin
        base_r <= FW'(idx_r);
        rng_r  <= (idx_r < prod);
      end else begin
        base_r <= FW'(prod);
        rng_r  <= (unit_r < units);
      end
    end

    if (state_r == S_RD) begin
      ea_r     <= ea;
      oa_r     <= oa;
      lo_row_r <= ROWI_W'(r0);
      odd_r    <= r0[0];
      col0_r   <= base_r[RB-1:0];
    end

    if (state_r == S_LOAD) begin
      pair_r <= pair;
      win_r  <= win_nxt;
      x_r    <= (op_r == OP_UPDATE) ? ist_rdata : bits_r;
    end

    case (state_r)
      S_ADDR: begin
        out_tau_r  <= tau_r;
        out_hid_r  <= hid_mask;
        out_w_r    <= '0;
        out_kind_r <= KIND_UPDATE;
      end
      S_EXEC: begin
        out_tau_r  <= 1'b0;
        out_hid_r  <= '0;
        out_kind_r <= KIND_RW;
        if (!rng_r) begin
          out_w_r <= '0;
        end else if (op_r == OP_WRITE) begin
          out_w_r <= wclip;
        end else begin
          out_w_r <= win_r[0];
        end
      end
      S_SUM: begin
        out_tau_r  <= parity_r ^ (rng_r && !pos);
        out_hid_r  <= hid_mask;
        out_w_r    <= '0;
        out_kind_r <= KIND_PARITY;
      end
      default: begin
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_tau_out        = out_tau_r;
  assign out_hidden_outputs = out_hid_r;
  assign out_weight_out     = out_w_r;
  assign out_result_kind    = out_kind_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a request is still in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  a_parity_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_PARITY) |-> parity_r)
    else $error("running parity not restarted after tau");

  a_weight_only_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != KIND_RW) |-> (out_weight_out == '0))
    else $error("weight output set on a non read/write result");

endmodule

`default_nettype wire

### hw/rtl/tpm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tpm_lane.sv
// One weight lane: signed product term and Hebbian weight step.
`default_nettype none

module tpm_lane (
  input  logic signed [tpm_pkg::W_W-1:0]    w,
  input  logic                              x,
  input  tpm_pkg::lane_ctl_t                ctl,
  output logic signed [tpm_pkg::TERM_W-1:0] term,
  output logic signed [tpm_pkg::W_W-1:0]    w_upd
);

  import tpm_pkg::*;

  logic signed [W_W:0] w_ext;
  logic signed [W_W:0] step;

  assign w_ext = {w[W_W-1], w};
  // +1 when input agrees with tau, else -1
  assign step  = (x == ctl.tau) ? 5'sd1 : -5'sd1;
  assign term  = x ? w_ext : -w_ext;
  assign w_upd = clip_w(w_ext + step, ctl.lim);

endmodule

`default_nettype wire

### hw/rtl/tpm_merge.sv
// Registered adder tree that merges the lane terms into the dot product.
`default_nettype none

module tpm_merge #(
  parameter int NL    = 30,
  parameter int SUM_W = 9
) (
  input  logic                                clk,
  input  logic [NL-1:0][tpm_pkg::TERM_W-1:0] terms,
  output logic signed [SUM_W-1:0]             sum
);

  import tpm_pkg::*;

  localparam int G  = 8;
  localparam int NG = (NL + G - 1) / G;

  logic signed [SUM_W-1:0] part_nxt [NG];
  logic signed [SUM_W-1:0] part_r   [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < G; j++) begin
        if (g * G + j < NL) begin
          part_nxt[g] = part_nxt[g] + SUM_W'($signed(terms[g * G + j]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      part_r[g] <= part_nxt[g];
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < NG; g++) begin
      sum = sum + part_r[g];
    end
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the tree parity machine core.
`timescale 1ns / 100ps

module testbench;
  import tpm_pkg::*;

  localparam int ITEMS       = 1750;
  localparam int PHASE_ITEMS = 250;
  localparam int QUIET_AFTER = ITEMS - 120;
  localparam int LIMIT       = 1500000;
  localparam int MAX_SHOWN   = 50;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [UNIT_W-1:0]     unit;
    logic [BITS_W-1:0]     bits;
    logic                  last;
    logic                  tau;
    logic [WIDX_W-1:0]     widx;
    logic signed [W_W-1:0] wval;
  } tpm_req_t;

  typedef struct packed {
    logic                  tau;
    logic [HID_W-1:0]      hid;
    logic signed [W_W-1:0] wout;
    logic [KIND_W-1:0]     kind;
  } tpm_res_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CDAT_W-1:0]     c_hc;
    logic [CDAT_W-1:0]     c_ipu;
    logic [CDAT_W-1:0]     c_mw;
    tpm_req_t              req;
    logic                  typed;
    logic signed [W_W-1:0] want_w;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [UNIT_W-1:0]     in_unit_index = '0;
  logic [BITS_W-1:0]     in_input_bits = '0;
  logic                  in_last_unit = 1'b0;
  logic                  in_tau_in = 1'b0;
  logic [WIDX_W-1:0]     in_weight_index = '0;
  logic signed [W_W-1:0] in_weight_value = '0;
  logic                  out_valid;
  logic                  out_tau_out;
  logic [HID_W-1:0]      out_hidden_outputs;
  logic signed [W_W-1:0] out_weight_out;
  logic [KIND_W-1:0]     out_result_kind;
  logic                  cfg_we = 1'b0;
  logic [CIDX_W-1:0]     cfg_index = '0;
  logic [CDAT_W-1:0]     cfg_wdata = '0;

  tree_parity_machine_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_unit_index      (in_unit_index),
    .in_input_bits      (in_input_bits),
    .in_last_unit       (in_last_unit),
    .in_tau_in          (in_tau_in),
    .in_weight_index    (in_weight_index),
    .in_weight_value    (in_weight_value),
    .out_valid          (out_valid),
    .out_tau_out        (out_tau_out),
    .out_hidden_outputs (out_hidden_outputs),
    .out_weight_out     (out_weight_out),
    .out_result_kind    (out_result_kind),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the machine state
  int              weights [UNITS_CAP*INPUTS_CAP];
  bit              unit_sign [UNITS_CAP];
  bit [BITS_W-1:0] unit_x [UNITS_CAP];
  bit              unit_x_set [UNITS_CAP];
  bit              parity_acc = 1'b1;
  bit              last_tau = 1'b1;
  int              hc_eff = 4;
  int              ipu_eff = 4;
  int              wbound = 3;

  tpm_res_t  answers_due[$];
  plan_row_t plan[$];
  int        fails = 0;
  int        sent_items = 0;
  int        cycles = 0;
  bit        idle_on = 1'b1;
  tpm_res_t  mon_want;

  function automatic int bound_weight(input int v);
    if (v > wbound) return wbound;
    if (v < -wbound) return -wbound;
    return v;
  endfunction

  function automatic int clamp_count(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [HID_W-1:0] sign_word();
    logic [HID_W-1:0] m;
    m = '0;
    for (int k = 0; k < hc_eff; k++) m[k] = unit_sign[k];
    return m;
  endfunction

  // Advances the shadow state by one request; returns 1 if it answers
  function automatic bit tpm_answer(input tpm_req_t r, output tpm_res_t a);
    int sum;
    int v;
    int idx;
    a = '0;
    case (r.op)
      OP_COMPUTE: begin
        if (r.unit < hc_eff) begin
          sum = 0;
          for (int i = 0; i < ipu_eff; i++) begin
            v = weights[r.unit*ipu_eff + i];
            sum += r.bits[i] ? v : -v;
          end
          // zero sum counts as -1
          unit_sign[r.unit] = (sum > 0);
          unit_x[r.unit] = r.bits;
          unit_x_set[r.unit] = 1'b1;
          if (sum <= 0) parity_acc = ~parity_acc;
        end
        if (!r.last) return 1'b0;
        a.tau = parity_acc;
        a.hid = sign_word();
        a.kind = KIND_PARITY;
        last_tau = parity_acc;
        parity_acc = 1'b1;
        return 1'b1;
      end
      OP_UPDATE: begin
        for (int k = 0; k < hc_eff; k++) begin
          if (unit_sign[k] == r.tau) begin
            for (int i = 0; i < ipu_eff; i++) begin
              idx = k*ipu_eff + i;
              weights[idx] = bound_weight(weights[idx] + ((unit_x[k][i] == r.tau) ? 1 : -1));
            end
          end
        end
        a.tau = r.tau;
        a.hid = sign_word();
        a.kind = KIND_UPDATE;
        return 1'b1;
      end
      default: begin
        idx = r.widx;
        v = 0;
        if (idx < hc_eff*ipu_eff) begin
          if (r.op == OP_WRITE) weights[idx] = bound_weight($signed(r.wval));
          v = weights[idx];
        end
        a.wout = v[W_W-1:0];
        a.kind = KIND_RW;
        return 1'b1;
      end
    endcase
  endfunction

  // An update must never reach a unit whose input word was never loaded
  function automatic bit update_ok(input logic tau);
    for (int k = 0; k < hc_eff; k++)
      if (unit_sign[k] == tau && !unit_x_set[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic tpm_req_t mk(input logic [OP_W-1:0] op, input int unit,
                                  input logic [BITS_W-1:0] bits, input logic last,
                                  input logic tau, input int widx, input int wval);
    tpm_req_t r;
    r.op = op;
    r.unit = unit[UNIT_W-1:0];
    r.bits = bits;
    r.last = last;
    r.tau = tau;
    r.widx = widx[WIDX_W-1:0];
    r.wval = wval[W_W-1:0];
    return r;
  endfunction

  function automatic tpm_req_t rand_req();
    return mk(OP_W'($urandom_range(0, 3)), $urandom_range(0, 31), BITS_W'($urandom),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 1023), $urandom_range(0, 15));
  endfunction

  function automatic void plan_req(input tpm_req_t r);
    plan_row_t s;
    s = '0;
    s.req = r;
    plan.push_back(s);
  endfunction

  function automatic void plan_rw(input logic [OP_W-1:0] op, input int widx, input int wval,
                                  input int want);
    plan_row_t s;
    s = '0;
    s.req = mk(op, 0, '0, 1'b0, 1'b0, widx, wval);
    s.typed = 1'b1;
    s.want_w = want[W_W-1:0];
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(input int hc, input int ipu, input int mw);
    plan_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.c_hc = hc[CDAT_W-1:0];
    s.c_ipu = ipu[CDAT_W-1:0];
    s.c_mw = mw[CDAT_W-1:0];
    plan.push_back(s);
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      fails++;
      if (fails <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  task automatic issue(input tpm_req_t r, input logic typed, input logic signed [W_W-1:0] want_w);
    tpm_res_t a;
    bit       has;
    in_opcode <= r.op;
    in_unit_index <= r.unit;
    in_input_bits <= r.bits;
    in_last_unit <= r.last;
    in_tau_in <= r.tau;
    in_weight_index <= r.widx;
    in_weight_value <= r.wval;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    has = tpm_answer(r, a);
    if (typed) begin
      a = '0;
      a.wout = want_w;
      a.kind = KIND_RW;
    end
    if (has) answers_due.push_back(a);
    sent_items++;
    if ($urandom_range(0, 59) == 0) idle_on = !idle_on;
    if (idle_on && sent_items < QUIET_AFTER && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Wait until the block is idle; a compute with no answer may still be running
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [CDAT_W-1:0] hc, input logic [CDAT_W-1:0] ipu,
                            input logic [CDAT_W-1:0] mw);
    cfg_we <= 1'b1;
    cfg_index <= REG_HIDDEN_COUNT;
    cfg_wdata <= hc;
    @(posedge clk);
    cfg_index <= REG_INPUTS_PER_UNIT;
    cfg_wdata <= ipu;
    @(posedge clk);
    cfg_index <= REG_MAX_WEIGHT;
    cfg_wdata <= mw;
    @(posedge clk);
    cfg_we <= 1'b0;
    hc_eff = clamp_count(hc, 4, 30);
    ipu_eff = clamp_count(ipu, 4, 30);
    wbound = clamp_count(mw & 5'd7, 3, 6);
  endtask

  task automatic run_phase(input logic [CDAT_W-1:0] hc, input logic [CDAT_W-1:0] ipu,
                           input logic [CDAT_W-1:0] mw);
    tpm_req_t r;
    int       goal;
    int       pick;
    drain();
    set_config(hc, ipu, mw);
    goal = sent_items + PHASE_ITEMS;
    repeat (16) begin
      r = rand_req();
      r.op = OP_WRITE;
      r.widx = WIDX_W'($urandom_range(0, hc_eff*ipu_eff - 1));
      issue(r, 1'b0, '0);
    end
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      r = rand_req();
      if (pick < 65) begin
        // one exchange round: every unit, then mostly learn from the emitted tau
        for (int u = 0; u < hc_eff; u++) begin
          r = rand_req();
          r.op = OP_COMPUTE;
          r.unit = UNIT_W'(u);
          r.last = (u == hc_eff - 1);
          issue(r, 1'b0, '0);
        end
        r = rand_req();
        r.op = OP_UPDATE;
        if ($urandom_range(0, 6) != 0) r.tau = last_tau;
        issue(r, 1'b0, '0);
      end else if (pick < 80) begin
        r.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        if ($urandom_range(0, 3) != 0) r.widx = WIDX_W'($urandom_range(0, hc_eff*ipu_eff - 1));
        issue(r, 1'b0, '0);
      end else if (pick < 92 || !update_ok(r.tau)) begin
        r.op = OP_COMPUTE;
        issue(r, 1'b0, '0);
      end else begin
        r.op = OP_UPDATE;
        issue(r, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("%0t: unexpected result, expected none, got kind %0d tau %0d hid %0h w %0d",
                   $time, out_result_kind, out_tau_out, out_hidden_outputs, out_weight_out);
      end else begin
        mon_want = answers_due.pop_front();
        check_field("result_kind", mon_want.kind, out_result_kind);
        check_field("tau_out", mon_want.tau, out_tau_out);
        check_field("hidden_outputs", mon_want.hid, out_hidden_outputs);
        check_field("weight_out", mon_want.wout, out_weight_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // reset state: zero weights, default sizes
    plan_rw(OP_READ, 0, 0, 0);
    plan_rw(OP_READ, 15, 0, 0);
    plan_rw(OP_READ, 16, 0, 0);
    plan_rw(OP_READ, 1023, 0, 0);
    plan_rw(OP_WRITE, 0, 7, 3);
    plan_rw(OP_WRITE, 1, -8, -3);
    plan_rw(OP_WRITE, 6, 2, 2);
    plan_rw(OP_WRITE, 16, 5, 0);
    plan_rw(OP_WRITE, 9, -1, -1);
    plan_req(mk(OP_COMPUTE, 0, 30'h3FFFFFFF, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 1, 30'h0, 1'b0, 1'b1, 0, 0));
    plan_req(mk(OP_COMPUTE, 2, 30'h2AAAAAAA, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 31, 30'h3FFFFFFF, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 3, 30'h15555555, 1'b1, 1'b0, 0, 0));
    plan_req(mk(OP_UPDATE, 0, 30'h0, 1'b0, 1'b1, 0, 0));
    plan_req(mk(OP_UPDATE, 0, 30'h0, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 30, 30'h3FFFFFFF, 1'b1, 1'b0, 0, 0));
    plan_req(mk(OP_READ, 0, 30'h0, 1'b0, 1'b0, 6, 0));
    plan_cfg(4, 4, 14);
    plan_rw(OP_WRITE, 0, 6, 6);
    plan_rw(OP_WRITE, 3, -7, -6);
    plan_cfg(4, 4, 2);
    // weight stays above the lowered bound until touched
    plan_rw(OP_READ, 0, 0, 6);
    plan_req(mk(OP_COMPUTE, 0, 30'h0000000F, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 1, 30'h00000005, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 2, 30'h0000000A, 1'b0, 1'b0, 0, 0));
    plan_req(mk(OP_COMPUTE, 3, 30'h00000000, 1'b1, 1'b0, 0, 0));
    plan_req(mk(OP_UPDATE, 0, 30'h0, 1'b0, 1'b0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (plan[j]) begin
      if (plan[j].is_cfg) begin
        drain();
        set_config(plan[j].c_hc, plan[j].c_ipu, plan[j].c_mw);
      end else begin
        issue(plan[j].req, plan[j].typed, plan[j].want_w);
      end
    end

    run_phase(5'd0, 5'd0, 5'd0);
    run_phase(5'd31, 5'd31, 5'd31);
    run_phase(5'd30, 5'd30, 5'd6);
    run_phase(5'd5, 5'd29, 5'd4);
    repeat (3) run_phase(CDAT_W'($urandom_range(0, 31)), CDAT_W'($urandom_range(0, 31)),
                         CDAT_W'($urandom_range(0, 31)));

    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fails == 0 && answers_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tpm_pkg.sv
hw/rtl/tpm_ram.sv
hw/rtl/tpm_lane.sv
hw/rtl/tpm_merge.sv
hw/rtl/tree_parity_machine_core.sv
tb/sv/testbench.sv
